// ===== rtl/core/biu_pkg.sv =====
// Package for the bilinear interpolation unit: widths, types and the divider step.
`default_nettype none
package biu_pkg;
    localparam int DataWidth = 32;
    localparam int InWidth   = 10 * DataWidth;
    localparam int SpanWidth = DataWidth + 1;
    localparam int WgtWidth  = 2 * SpanWidth;
    localparam int ProdWidth = DataWidth + WgtWidth;
    localparam int NumWidth  = ProdWidth + 2;
    localparam int DenWidth  = 2 * SpanWidth;
    localparam int QuoWidth  = NumWidth;
    localparam int RemWidth  = DenWidth + 1;

    typedef enum logic [1:0] {
        T_MODE_FULL = 2'd0,
        T_MODE_NEAR = 2'd1
    } t_mode;

    // One item moving through the divider chain.
    typedef struct packed {
        logic                  valid;
        t_mode                 mode;
        logic [DataWidth-1:0]  near_value;
        logic                  neg;
        logic [NumWidth-1:0]   num_mag;
        logic [DenWidth-1:0]   den_mag;
        logic [RemWidth-1:0]   rem;
        logic [QuoWidth-1:0]   quo;
    } t_div_item;
endpackage
`default_nettype wire

// ===== rtl/core/biu_front.sv =====
// Front stages: spans, weights, products and numerator of the interpolation.
`default_nettype none
module biu_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic                       i_valid,
    input  wire logic [biu_pkg::InWidth-1:0] i_data,
    output biu_pkg::t_div_item              o_item
);
    localparam int W = biu_pkg::DataWidth;
    localparam int S = biu_pkg::SpanWidth;
    localparam int G = biu_pkg::WgtWidth;
    localparam int P = biu_pkg::ProdWidth;
    localparam int N = biu_pkg::NumWidth;
    localparam int D = biu_pkg::DenWidth;
    localparam int L = W + S + 1;

    logic signed [W-1:0] x1, x2, y1, y2, q11, q12, q21, q22, px, py;
    assign x1  = i_data[0*W +: W];
    assign x2  = i_data[1*W +: W];
    assign y1  = i_data[2*W +: W];
    assign y2  = i_data[3*W +: W];
    assign q11 = i_data[4*W +: W];
    assign q12 = i_data[5*W +: W];
    assign q21 = i_data[6*W +: W];
    assign q22 = i_data[7*W +: W];
    assign px  = i_data[8*W +: W];
    assign py  = i_data[9*W +: W];

    // Stage 1: spans, weights, nearest-corner choice.
    logic                r_v1;
    biu_pkg::t_mode      r_mode1;
    logic [W-1:0]        r_near1;
    logic signed [S-1:0] r_dx1, r_dy1, r_wxl1, r_wxh1, r_wyl1, r_wyh1;
    logic signed [W-1:0] r_q11_1, r_q12_1, r_q21_1, r_q22_1;

    logic signed [S-1:0] dx, dy, wxl, wxh, wyl, wyh;
    logic [S-1:0]        ax, bx, ay, by;
    biu_pkg::t_mode      n_mode1;
    logic [W-1:0]        n_near1;

    always_comb begin
        dx  = S'(x2) - S'(x1);
        dy  = S'(y2) - S'(y1);
        wxl = S'(x2) - S'(px);
        wxh = S'(px) - S'(x1);
        wyl = S'(y2) - S'(py);
        wyh = S'(py) - S'(y1);
        ax  = wxh[S-1] ? S'(-wxh) : wxh;
        bx  = wxl[S-1] ? S'(-wxl) : wxl;
        ay  = wyh[S-1] ? S'(-wyh) : wyh;
        by  = wyl[S-1] ? S'(-wyl) : wyl;
        n_mode1 = biu_pkg::T_MODE_NEAR;
        n_near1 = q11;
        if (dx != '0 && dy != '0) begin
            n_mode1 = biu_pkg::T_MODE_FULL;
        end else if (dx == '0 && dy == '0) begin
            n_near1 = q11;
        end else if (dy == '0) begin
            n_near1 = (ax < bx) ? q11 : q21;
        end else begin
            n_near1 = (ay < by) ? q11 : q12;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
        end
        if (i_adv) begin
            r_mode1 <= n_mode1;
            r_near1 <= n_near1;
            r_dx1 <= dx;   r_dy1 <= dy;
            r_wxl1 <= wxl; r_wxh1 <= wxh; r_wyl1 <= wyl; r_wyh1 <= wyh;
            r_q11_1 <= q11; r_q12_1 <= q12; r_q21_1 <= q21; r_q22_1 <= q22;
        end
    end

    // Stage 2: weight products and denominator, each about 33x33.
    logic                r_v2;
    biu_pkg::t_mode      r_mode2;
    logic [W-1:0]        r_near2;
    logic signed [G-1:0] r_wll, r_whl, r_wlh, r_whh;
    logic signed [D-1:0] r_den2;
    logic signed [W-1:0] r_q11_2, r_q12_2, r_q21_2, r_q22_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v2 <= r_v1;
        end
        if (i_adv) begin
            r_mode2 <= r_mode1;
            r_near2 <= r_near1;
            r_wll <= G'(r_wxl1 * r_wyl1);
            r_whl <= G'(r_wxh1 * r_wyl1);
            r_wlh <= G'(r_wxl1 * r_wyh1);
            r_whh <= G'(r_wxh1 * r_wyh1);
            r_den2 <= D'(r_dx1 * r_dy1);
            r_q11_2 <= r_q11_1; r_q12_2 <= r_q12_1;
            r_q21_2 <= r_q21_1; r_q22_2 <= r_q22_1;
        end
    end

    // Stage 3: sample times the low and the high half of each weight.
    logic                r_v3;
    biu_pkg::t_mode      r_mode3;
    logic [W-1:0]        r_near3;
    logic signed [L-1:0] r_lo3 [4];
    logic signed [L-1:0] r_hi3 [4];
    logic signed [D-1:0] r_den3;
    logic signed [W-1:0] qs [4];
    logic signed [G-1:0] ws [4];

    assign qs[0] = r_q11_2;
    assign qs[1] = r_q21_2;
    assign qs[2] = r_q12_2;
    assign qs[3] = r_q22_2;
    assign ws[0] = r_wll;
    assign ws[1] = r_whl;
    assign ws[2] = r_wlh;
    assign ws[3] = r_whh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v3 <= r_v2;
        end
        if (i_adv) begin
            r_mode3 <= r_mode2;
            r_near3 <= r_near2;
            for (int k = 0; k < 4; k++) begin
                r_lo3[k] <= L'(qs[k] * $signed({1'b0, ws[k][S-1:0]}));
                r_hi3[k] <= L'(qs[k] * $signed(ws[k][G-1:S]));
            end
            r_den3 <= r_den2;
        end
    end

    // Stage 4: join the halves into full products.
    logic                r_v4;
    biu_pkg::t_mode      r_mode4;
    logic [W-1:0]        r_near4;
    logic signed [P-1:0] r_p4 [4];
    logic signed [D-1:0] r_den4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v4 <= r_v3;
        end
        if (i_adv) begin
            r_mode4 <= r_mode3;
            r_near4 <= r_near3;
            for (int k = 0; k < 4; k++) begin
                r_p4[k] <= (P'(r_hi3[k]) <<< S) + P'(r_lo3[k]);
            end
            r_den4 <= r_den3;
        end
    end

    // Stage 5: numerator sum and sign split for the divider.
    logic signed [N-1:0] num;
    assign num = N'(r_p4[0]) + N'(r_p4[1]) + N'(r_p4[2]) + N'(r_p4[3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_item.valid <= 1'b0;
        end else if (i_adv) begin
            o_item.valid <= r_v4;
        end
        if (i_adv) begin
            o_item.mode       <= r_mode4;
            o_item.near_value <= r_near4;
            o_item.neg        <= num[N-1] ^ r_den4[D-1];
            o_item.num_mag    <= num[N-1] ? N'(-num) : num;
            o_item.den_mag    <= r_den4[D-1] ? D'(-r_den4) : r_den4;
            o_item.rem        <= '0;
            o_item.quo        <= '0;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/biu_div_cell.sv =====
// One restoring-division cell: produces one quotient bit and hands the item on.
`default_nettype none
module biu_div_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_adv,
    input  wire logic [$clog2(biu_pkg::NumWidth)-1:0] i_bit,
    input  biu_pkg::t_div_item      i_item,
    output biu_pkg::t_div_item      o_item
);
    localparam int R = biu_pkg::RemWidth;

    biu_pkg::t_div_item n_item;
    logic [R-1:0]       shifted;
    logic [R-1:0]       diff;

    always_comb begin
        n_item  = i_item;
        shifted = {i_item.rem[R-2:0], i_item.num_mag[i_bit]};
        diff    = shifted - R'(i_item.den_mag);
        if (!diff[R-1]) begin
            n_item.rem = diff;
            n_item.quo[i_bit] = 1'b1;
        end else begin
            n_item.rem = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_item.valid <= 1'b0;
        end else if (i_adv) begin
            o_item.valid <= i_item.valid;
        end
        if (i_adv) begin
            o_item.mode       <= n_item.mode;
            o_item.near_value <= n_item.near_value;
            o_item.neg        <= n_item.neg;
            o_item.num_mag    <= n_item.num_mag;
            o_item.den_mag    <= n_item.den_mag;
            o_item.rem        <= n_item.rem;
            o_item.quo        <= n_item.quo;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/bilinear_interpolation_unit.sv =====
// Top level of the bilinear interpolation unit: front stages, divider cell chain, output.
//
//  channel | dir | handshake               | payload
//  s_axis  | in  | i_s_axis_tvalid/tready  | ten 32-bit Q16.16 fields
//  m_axis  | out | o_m_axis_tvalid/tready  | interpolated, 32-bit Q16.16
//
// One item per cycle while the output is taken; the path is 5 front stages, one divider
// cell per quotient bit (NumWidth = 100 cells), and one output register.
// The whole pipeline advances together while the output register is empty or taken;
// a held output stalls every stage and drops s_axis tready.
// Synchronous active-low reset clears all valid bits; tready stays low during reset.
`default_nettype none
module bilinear_interpolation_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // x1, x2, y1, y2, q11, q12, q21, q22, x, y from the lowest bit up
    input  wire logic [biu_pkg::InWidth-1:0]     i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // interpolated
    output logic [biu_pkg::DataWidth-1:0]        o_m_axis_tdata
);
    localparam int W    = biu_pkg::DataWidth;
    localparam int N    = biu_pkg::NumWidth;
    localparam int Q    = biu_pkg::QuoWidth;
    localparam int BitW = $clog2(N);

    logic adv;
    assign adv = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = adv && i_rst_n;

    biu_pkg::t_div_item chain [0:N];

    biu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .o_item  (chain[0])
    );

    for (genvar g = 0; g < N; g++) begin : g_cell
        biu_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_bit   (BitW'(N - 1 - g)),
            .i_item  (chain[g]),
            .o_item  (chain[g+1])
        );
    end

    // Sign, saturate, or pass the nearest corner.
    biu_pkg::t_div_item last;
    logic [Q:0]         sq;
    logic [W-1:0]       n_out;
    assign last = chain[N];
    always_comb begin
        sq = last.neg ? (Q+1)'(-{1'b0, last.quo}) : {1'b0, last.quo};
        if (last.mode == biu_pkg::T_MODE_NEAR) begin
            n_out = last.near_value;
        end else if (!sq[Q] && sq[Q-1:W-1] != '0) begin
            n_out = {1'b0, {(W-1){1'b1}}};
        end else if (sq[Q] && sq[Q-1:W-1] != {(Q-W+1){1'b1}}) begin
            n_out = {1'b1, {(W-1){1'b0}}};
        end else begin
            n_out = sq[W-1:0];
        end
    end

    logic         r_valid;
    logic [W-1:0] r_data;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= last.valid;
        end
        if (adv) begin
            r_data <= n_out;
        end
    end
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output item dropped under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("ready does not follow output slot");
    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(last.valid))
        else $error("chain moved while stalled");
`endif
endmodule
`default_nettype wire
